### sv/pctd_pkg.sv
package pctd_pkg;

    // table geometry and code limits
    localparam int TABLE_ENTRIES   = 256;
    localparam int MAX_CODE_LENGTH = 16;

    // fixed field widths of the item and result beats
    localparam int ACT_W  = 2;
    localparam int IDX_W  = 8;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;

    // derived widths
    localparam int TIDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PC_W   = MAX_CODE_LENGTH;
    localparam int PLEN_W = $clog2(MAX_CODE_LENGTH + 1);
    localparam int LCMP_W = (PLEN_W > LEN_W) ? PLEN_W : LEN_W;
    localparam int CCMP_W = (PC_W > CODE_W) ? PC_W : CODE_W;
    localparam int ENT_W  = SYM_W + CODE_W + LEN_W;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BIT   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take_load;
        logic take_bit;
        logic take_clear;
        logic issue;
        logic capture_hit;
        logic capture_err;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic at_max;
        logic out_free;
    } ctrl_status_t;

    // keeps the low len bits of a code word
    function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < CODE_W; i++)
        begin
            m[i] = (int'(len) > i);
        end
        return m;
    endfunction

endpackage

### sv/pctd_if.sv
interface pctd_in_if;
    import pctd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  entry_index;
    logic [SYM_W-1:0]  entry_symbol;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_length;
    logic              code_bit;

    modport source (
        output valid, action, entry_index, entry_symbol, entry_code, entry_length, code_bit,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_symbol, entry_code, entry_length, code_bit,
        output ready
    );
endinterface

interface pctd_out_if;
    import pctd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             status;

    modport source (
        output valid, symbol, status,
        input  ready
    );
    modport sink (
        input  valid, symbol, status,
        output ready
    );
endinterface

### sv/prefix_code_table_decoder.sv
// Bit-serial prefix code (Huffman) decoder working from a 256-slot code table.
// Item beats carry an action: load writes one slot (symbol, code, length, where
// length zero empties the slot), bit appends one stream bit to the partial code,
// clear drops leftover bits; the unused action code is taken and ignored.
// When the partial code matches a slot in both length and bits, the symbol of
// the lowest matching slot comes out with status 0 and the partial code is
// cleared; when it reaches 16 bits with no match, a beat with symbol 0 and
// status 1 comes out and the partial code is cleared. Loads, clears and bits
// that neither match nor reach the limit give no result beat.
// Load, clear and unused beats leave the sequencer idle. A bit beat starts a
// scan from slot 0 that stops at the first matching slot, or after the last
// slot when no slot matches; a result then passes to the output register once that register is free.
// The scan rate is set by the table memory's single read port: the scan compares
// one slot per cycle against the partial code. A finished result waits in its
// own output register, so new item beats are taken while it is unread.
// Slot emptiness after reset comes from per-slot valid flops, so there is no
// clearing pass; the block takes beats from the first cycle after reset.
module prefix_code_table_decoder (
    input  logic     clk,
    input  logic     rst_n,
    pctd_in_if.sink  item,
    pctd_out_if.source result
);
    import pctd_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencer: owns the item handshake and the scan control
    pctd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_action (item.action),
        .in_ready  (item.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // table memory, partial code, compare and result registers
    pctd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .entry_index  (item.entry_index),
        .entry_symbol (item.entry_symbol),
        .entry_code   (item.entry_code),
        .entry_length (item.entry_length),
        .code_bit     (item.code_bit),
        .result       (result)
    );

endmodule

### sv/pctd_ctrl.sv
module pctd_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [pctd_pkg::ACT_W-1:0] in_action,
    output logic                     in_ready,
    output pctd_pkg::ctrl_cmd_t      cmd,
    input  pctd_pkg::ctrl_status_t   status
);
    import pctd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && in_action == ACT_BIT)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.scan_end)
                begin
                    state_next = status.at_max ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (in_action)
                        ACT_LOAD:  cmd.take_load  = 1'b1;
                        ACT_BIT:   cmd.take_bit   = 1'b1;
                        ACT_CLEAR: cmd.take_clear = 1'b1;
                        default:   ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    cmd.capture_hit = 1'b1;
                end
                else if (status.scan_end)
                begin
                    cmd.capture_err = status.at_max;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_bit_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_action == ACT_BIT) |=> (state_reg == ST_SCAN))
        else $error("bit beat did not start a table scan");

    a_emit_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && $past(state_reg) != ST_EMIT) |-> ($past(state_reg) == ST_SCAN))
        else $error("emit state entered without a finished scan");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !(cmd.take_load || cmd.take_bit || cmd.take_clear))
        else $error("beat taken during a scan");

endmodule

### sv/pctd_datapath.sv
module pctd_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pctd_pkg::ctrl_cmd_t         cmd,
    output pctd_pkg::ctrl_status_t      status,
    input  logic [pctd_pkg::IDX_W-1:0]  entry_index,
    input  logic [pctd_pkg::SYM_W-1:0]  entry_symbol,
    input  logic [pctd_pkg::CODE_W-1:0] entry_code,
    input  logic [pctd_pkg::LEN_W-1:0]  entry_length,
    input  logic                        code_bit,
    pctd_out_if.source                  result
);
    import pctd_pkg::*;

    // code table: symbol, masked code, length
    logic [ENT_W-1:0]         mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] vld_reg;

    logic [ENT_W-1:0]  rd_data_reg;
    logic              ent_vld_reg;
    logic              rd_vld_reg;
    logic              rd_last_reg;
    logic [TIDX_W-1:0] scan_idx_reg;

    logic [PC_W-1:0]   pcode_reg;
    logic [PLEN_W-1:0] plen_reg;

    logic [SYM_W-1:0]  res_sym_reg;
    logic              res_status_reg;
    logic              out_valid_reg;
    logic [SYM_W-1:0]  out_sym_reg;
    logic              out_status_reg;

    logic              in_range;
    logic              wr_en;
    logic [TIDX_W-1:0] waddr;
    logic [SYM_W-1:0]  rd_sym;
    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;
    logic              hit;

    assign in_range = ({1'b0, entry_index} < (IDX_W + 1)'(TABLE_ENTRIES));
    assign wr_en    = cmd.take_load && in_range;
    assign waddr    = entry_index[TIDX_W-1:0];

    assign rd_sym  = rd_data_reg[ENT_W-1 -: SYM_W];
    assign rd_code = rd_data_reg[LEN_W +: CODE_W];
    assign rd_len  = rd_data_reg[LEN_W-1:0];

    // single port table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= {entry_symbol, entry_code & code_mask(entry_length), entry_length};
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[scan_idx_reg];
            ent_vld_reg <= vld_reg[scan_idx_reg];
        end
    end

    // slot written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // scan address and read pipeline flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= cmd.issue;
            rd_last_reg <= cmd.issue && (scan_idx_reg == TIDX_W'(TABLE_ENTRIES - 1));
            if (cmd.take_bit)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // partial code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcode_reg <= '0;
            plen_reg  <= '0;
        end
        else if (cmd.take_bit)
        begin
            pcode_reg <= PC_W'({pcode_reg, code_bit});
            plen_reg  <= plen_reg + 1'b1;
        end
        else if (cmd.take_clear || cmd.capture_hit || cmd.capture_err)
        begin
            pcode_reg <= '0;
            plen_reg  <= '0;
        end
    end

    // compare of the slot read in the previous cycle
    assign hit = rd_vld_reg && ent_vld_reg
              && (LCMP_W'(rd_len) == LCMP_W'(plen_reg))
              && (CCMP_W'(rd_code) == CCMP_W'(pcode_reg));

    assign status.hit      = hit;
    assign status.scan_end = rd_vld_reg && rd_last_reg && !hit;
    assign status.at_max   = (plen_reg == PLEN_W'(MAX_CODE_LENGTH));
    assign status.out_free = !out_valid_reg || result.ready;

    // pending result
    always_ff @(posedge clk)
    begin
        if (cmd.capture_hit)
        begin
            res_sym_reg    <= rd_sym;
            res_status_reg <= STATUS_OK;
        end
        else if (cmd.capture_err)
        begin
            res_sym_reg    <= '0;
            res_status_reg <= STATUS_MISS;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_sym_reg    <= res_sym_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.symbol = out_sym_reg;
    assign result.status = out_status_reg;

    a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= PLEN_W'(MAX_CODE_LENGTH))
        else $error("partial code longer than the maximum code length");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || result.ready))
        else $error("result overwrites a beat not yet taken");

    a_capture_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture_hit || cmd.capture_err) |=> (plen_reg == '0))
        else $error("partial code kept after a result");

endmodule

### sim/tb_prefix_code_table_decoder.sv
`timescale 1ns / 100ps

module tb_prefix_code_table_decoder;
    import pctd_pkg::*;

    // the action code the block takes and drops
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int STIM_ITEMS   = 1525;             // directed plus random beats that do work
    localparam int QUIET_TAIL   = 150;              // no idling once this few beats remain
    localparam int HOLD_AT      = 200;              // accepted beats before the long output hold
    localparam int HOLD_LEN     = 3000;             // length of that hold in cycles
    localparam int DRAIN_CYCLES = TABLE_ENTRIES + 20;
    localparam int CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  idx;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              code_bit;
    } code_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             status;
    } decoded_t;

    logic clk;
    logic rst_n;

    pctd_in_if  item_bus ();
    pctd_out_if result_bus ();

    prefix_code_table_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    // beats waiting to be driven, and decoded results waiting to come out
    code_item_t pending_beats [$];
    decoded_t   awaited_results [$];

    // shadow of the code table and the partial code
    logic [SYM_W-1:0]  shadow_sym  [TABLE_ENTRIES];
    logic [CODE_W-1:0] shadow_code [TABLE_ENTRIES];
    logic [LEN_W-1:0]  shadow_len  [TABLE_ENTRIES];
    logic [PC_W-1:0]   shadow_partial;
    int                shadow_plen;

    // slots the stimulus has left non-empty, so a new table can wipe them
    bit slot_live [TABLE_ENTRIES];

    int stim_items;
    int beats_accepted;
    int n_loads, n_bits, n_clears, n_unused;
    int n_symbols, n_misses;
    int result_beats;
    int mismatches;
    int cycle_count;
    int hold_stall_cycles;

    code_item_t live_beat;
    int         send_gap;
    int         recv_stall;
    decoded_t   want;
    logic       long_hold;
    int         hold_cycles;
    bit         hold_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_beat(input logic [ACT_W-1:0] act, input int idx, input int sym,
                             input int code, input int len, input int bitv);
        code_item_t b;
        b.action   = act;
        b.idx      = IDX_W'(idx);
        b.sym      = SYM_W'(sym);
        b.code     = CODE_W'(code);
        b.len      = LEN_W'(len);
        b.code_bit = bitv[0];
        pending_beats = {pending_beats, b};
        if (act == ACT_LOAD)
        begin
            slot_live[b.idx] = (b.len != '0);
        end
        if (act != ACT_UNUSED)
        begin
            stim_items++;
        end
    endtask

    task automatic push_load(input int idx, input int sym, input int code, input int len);
        push_beat(ACT_LOAD, idx, sym, code, len, $urandom_range(0, 1));
    endtask

    // fields a bit or clear beat does not use still get random values
    task automatic push_bit(input int b);
        push_beat(ACT_BIT, $urandom, $urandom, $urandom, $urandom, b);
    endtask

    task automatic push_clear();
        push_beat(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    endtask

    // empty every slot that still holds a code, with junk in the other fields
    task automatic wipe_table();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (slot_live[i])
            begin
                push_load(i, $urandom, $urandom, 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // prediction: apply one accepted beat to the shadow table and
    // queue the result it causes, if any
    // ------------------------------------------------------------------

    task automatic decode_step(input code_item_t b);
        logic [CODE_W-1:0] keep;
        decoded_t          r;
        bit                hit;
        hit = 1'b0;
        r   = '0;
        case (b.action)
            ACT_LOAD:
            begin
                // code bits above the length are dropped on the way in
                keep = (b.len >= CODE_W) ? {CODE_W{1'b1}}
                                         : ((CODE_W'(1) << b.len) - CODE_W'(1));
                if (int'(b.idx) < TABLE_ENTRIES)
                begin
                    shadow_sym[b.idx]  = b.sym;
                    shadow_code[b.idx] = b.code & keep;
                    shadow_len[b.idx]  = b.len;
                end
                n_loads++;
            end
            ACT_CLEAR:
            begin
                shadow_partial = '0;
                shadow_plen    = 0;
                n_clears++;
            end
            ACT_BIT:
            begin
                // first bit ends up most significant
                shadow_partial = {shadow_partial[PC_W-2:0], b.code_bit};
                shadow_plen++;
                n_bits++;
                // lowest matching slot wins
                for (int i = 0; i < TABLE_ENTRIES && !hit; i++)
                begin
                    if (shadow_len[i] != '0 && int'(shadow_len[i]) == shadow_plen &&
                        shadow_code[i] == shadow_partial)
                    begin
                        hit      = 1'b1;
                        r.symbol = shadow_sym[i];
                        r.status = STATUS_OK;
                    end
                end
                // a full-length partial code with no match is an error
                if (!hit && shadow_plen >= MAX_CODE_LENGTH)
                begin
                    hit      = 1'b1;
                    r.symbol = '0;
                    r.status = STATUS_MISS;
                end
                if (hit)
                begin
                    awaited_results = {awaited_results, r};
                    shadow_partial = '0;
                    shadow_plen    = 0;
                end
            end
            default:
            begin
                n_unused++;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus: directed beats, then random tables and streams
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int               leaf_code [$];
        int               leaf_len [$];
        bit               slot_taken [TABLE_ENTRIES];
        int               n_leaves;
        int               k, c, l, s, dropped, pick, cut, kind;
        logic [CODE_W-1:0] word;

        stim_items = 0;
        foreach (slot_live[i])
        begin
            slot_live[i] = 1'b0;
        end

        // stray code bits above length one; duplicate code, lower slot must win;
        // overlong entry in the top slot
        push_load(0, 8'hA5, 16'hFFFF, 1);
        push_load(10, 8'h11, 16'hFFFD, 2);
        push_load(200, 8'h22, 16'h0001, 2);
        push_load(255, 8'hFF, 16'hFFFF, 31);
        push_bit(1);
        push_bit(0);
        push_bit(1);
        // leftover bit thrown away by a clear
        push_bit(0);
        push_clear();
        push_bit(1);
        push_beat(ACT_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 31, 1);
        // sixteen zeros with slot 0 emptied mid-code run into the length limit
        push_bit(0);
        push_load(0, 8'h00, 16'h0000, 0);
        repeat (MAX_CODE_LENGTH - 1)
        begin
            push_bit(0);
        end

        while (stim_items < STIM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                // well-formed: fresh prefix code table, then a stream of its codes
                push_clear();
                if ($urandom_range(0, 4) != 0)
                begin
                    wipe_table();
                end

                // grow a prefix code by splitting leaves; favoring the newest
                // leaf makes long chains that reach the full code length
                leaf_code = '{0, 1};
                leaf_len  = '{1, 1};
                n_leaves  = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 20)
                                                        : $urandom_range(2, 10);
                while (leaf_code.size() < n_leaves)
                begin
                    k = $urandom_range(0, 1) ? leaf_code.size() - 1
                                             : $urandom_range(0, leaf_code.size() - 1);
                    if (leaf_len[k] < MAX_CODE_LENGTH)
                    begin
                        c = leaf_code[k];
                        l = leaf_len[k];
                        leaf_code.delete(k);
                        leaf_len.delete(k);
                        leaf_code = {leaf_code, c * 2, c * 2 + 1};
                        leaf_len  = {leaf_len, l + 1, l + 1};
                    end
                end

                // mostly low slots keep the scan short; now and then one leaf is
                // left out so the code is incomplete
                foreach (slot_taken[i])
                begin
                    slot_taken[i] = 1'b0;
                end
                dropped = ($urandom_range(0, 4) == 0) ? $urandom_range(0, leaf_code.size() - 1)
                                                      : -1;
                for (int j = 0; j < leaf_code.size(); j++)
                begin
                    do
                    begin
                        s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TABLE_ENTRIES - 1)
                                                        : $urandom_range(0, 47);
                    end
                    while (slot_taken[s]);
                    slot_taken[s] = 1'b1;
                    word = CODE_W'(leaf_code[j]) | CODE_W'($urandom << leaf_len[j]);
                    if (j != dropped)
                    begin
                        push_load(s, $urandom, word, leaf_len[j]);
                    end
                end
                // second copy of one code elsewhere: the lower slot decides
                if ($urandom_range(0, 5) == 0)
                begin
                    do
                    begin
                        s = $urandom_range(0, TABLE_ENTRIES - 1);
                    end
                    while (slot_taken[s]);
                    slot_taken[s] = 1'b1;
                    pick = $urandom_range(0, leaf_code.size() - 1);
                    push_load(s, $urandom, leaf_code[pick], leaf_len[pick]);
                end

                repeat ($urandom_range(8, 30))
                begin
                    pick = $urandom_range(0, leaf_code.size() - 1);
                    // a broken symbol stops short and is cleared
                    cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, leaf_len[pick] - 1)
                                                       : leaf_len[pick];
                    for (int b = leaf_len[pick] - 1; b >= leaf_len[pick] - cut; b--)
                    begin
                        push_bit((leaf_code[pick] >> b) & 1);
                        // table change in the middle of a code
                        if ($urandom_range(0, 39) == 0)
                        begin
                            push_load($urandom_range(48, TABLE_ENTRIES - 1), $urandom, $urandom,
                                      $urandom_range(0, 31));
                        end
                    end
                    if (cut < leaf_len[pick])
                    begin
                        push_clear();
                    end
                    if ($urandom_range(0, 19) == 0)
                    begin
                        push_beat(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                  $urandom_range(0, 1));
                    end
                end
            end
            else if (kind < 8)
            begin
                // one full-length code plus an overlong one; random words mostly miss
                push_clear();
                wipe_table();
                s    = $urandom_range(0, 63);
                word = CODE_W'($urandom);
                push_load(s, $urandom, word, MAX_CODE_LENGTH);
                push_load($urandom_range(64, 127), $urandom, $urandom, $urandom_range(17, 31));
                repeat ($urandom_range(2, 3))
                begin
                    c = $urandom_range(0, 1) ? int'(word) : int'(CODE_W'($urandom));
                    for (int b = MAX_CODE_LENGTH - 1; b >= 0; b--)
                    begin
                        push_bit((c >> b) & 1);
                    end
                end
            end
            else
            begin
                // noise: any action, any fields
                repeat ($urandom_range(4, 16))
                begin
                    push_beat(ACT_W'($urandom), $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(0, 1));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // item driver: offers queued beats, predicts on each accepted beat
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_bus.valid        <= 1'b0;
            item_bus.action       <= '0;
            item_bus.entry_index  <= '0;
            item_bus.entry_symbol <= '0;
            item_bus.entry_code   <= '0;
            item_bus.entry_length <= '0;
            item_bus.code_bit     <= 1'b0;
            live_beat      = '0;
            send_gap       = 0;
            beats_accepted = 0;
            shadow_partial = '0;
            shadow_plen    = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                shadow_sym[i]  = '0;
                shadow_code[i] = '0;
                shadow_len[i]  = '0;
            end
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                decode_step(live_beat);
                beats_accepted++;
            end
            // move on only when no beat is held waiting for ready
            if (!item_bus.valid || item_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_bus.valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    live_beat = pending_beats.pop_front();
                    item_bus.valid        <= 1'b1;
                    item_bus.action       <= live_beat.action;
                    item_bus.entry_index  <= live_beat.idx;
                    item_bus.entry_symbol <= live_beat.sym;
                    item_bus.entry_code   <= live_beat.code;
                    item_bus.entry_length <= live_beat.len;
                    item_bus.code_bit     <= live_beat.code_bit;
                    // idle burst after this beat goes through
                    if (pending_beats.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0)
                    begin
                        send_gap = $urandom_range(1, 6);
                    end
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random stalls, checks each beat against the oldest
    // expected result
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            recv_stall   = 0;
            result_beats = 0;
            mismatches   = 0;
            n_symbols    = 0;
            n_misses     = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                result_beats++;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result beat %0d with nothing expected: symbol %h status %0d",
                                 result_beats, result_bus.symbol, result_bus.status);
                    end
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_bus.symbol !== want.symbol || result_bus.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("beat %0d: expected symbol %h status %0d, got %h %0d",
                                     result_beats, want.symbol, want.status,
                                     result_bus.symbol, result_bus.status);
                        end
                    end
                    else if (want.status == STATUS_MISS)
                    begin
                        n_misses++;
                    end
                    else
                    begin
                        n_symbols++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
            end
            else if (pending_beats.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
            begin
                recv_stall = $urandom_range(1, 6);
            end
            result_bus.ready <= !long_hold && (recv_stall == 0);
        end
    end

    // one long output hold so the result register fills and the input backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold <= 1'b0;
            hold_cycles       = 0;
            hold_done         = 1'b0;
            hold_stall_cycles = 0;
        end
        else
        begin
            if (long_hold && item_bus.valid && !item_bus.ready)
            begin
                hold_stall_cycles++;
            end
            if (!hold_done && !long_hold && beats_accepted >= HOLD_AT)
            begin
                long_hold <= 1'b1;
                hold_cycles = HOLD_LEN;
            end
            else if (long_hold)
            begin
                if (hold_cycles == 0)
                begin
                    long_hold <= 1'b0;
                    hold_done = 1'b1;
                end
                else
                begin
                    hold_cycles--;
                end
            end
        end
    end

    // cycle guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, awaited_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // reset, drain, verdict
    // ------------------------------------------------------------------

    initial
    begin : run_control
        cycle_count = 0;
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || item_bus.valid || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        // a bit beat with no match can still be scanning; give any stray result time to show
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $display("%0d expected results never came out", awaited_results.size());
            mismatches += awaited_results.size();
        end

        $display("%0d beats taken: %0d loads, %0d code bits, %0d clears, %0d unused actions",
                 beats_accepted, n_loads, n_bits, n_clears, n_unused);
        $display("%0d symbols, %0d length-limit misses; input stalled %0d cycles in the hold",
                 n_symbols, n_misses, hold_stall_cycles);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
